/* src/assert_macros.svh */
// Assertion macros shared by the event waiter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high
`define EWW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define EWW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ewait_pkg.sv */
// Types and constants of the event waiter with LIFO wakeup
package ewait_pkg;

  localparam int TASK_ID_BITS    = 8;
  localparam int DEF_MAX_WAITERS = 16;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_RESET  = 2'd1;
  localparam logic [1:0] REQ_WAIT   = 2'd2;
  localparam logic [1:0] REQ_CANCEL = 2'd3;

  localparam logic MODE_AUTO      = 1'b1;
  localparam logic REG_EVENT_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [TASK_ID_BITS-1:0] task_id;
  } ewait_req_t;

  typedef struct packed {
    logic [TASK_ID_BITS-1:0] woken_task;
    logic                    wake_valid;
    logic                    must_block;
    logic                    flag_now;
    logic                    stack_overflow;
    logic                    last_result;
  } ewait_res_t;

  typedef struct packed {
    logic                    valid;
    logic [TASK_ID_BITS-1:0] id;
  } slot_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_SEARCH
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic                    compact;
    logic [TASK_ID_BITS-1:0] key;
  } chain_ctl_t;

  typedef struct packed {
    slot_t top;
    logic  second_valid;
    logic  full;
    logic  hit;
    logic  stop;
  } chain_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MSET,
    ST_CANCEL
  } ewait_state_t;

endpackage

/* src/ewait_cell.sv */
// One waiter slot of the stack chain with its search token
module ewait_cell import ewait_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  input  slot_t      prev_slot,
  input  slot_t      next_slot,
  input  logic       prev_tok,
  output slot_t      slot,
  output logic       tok,
  output logic       hit
);

  logic                    valid;
  logic [TASK_ID_BITS-1:0] id;
  slot_t                   slot_next;

  assign slot = '{valid: valid, id: id};
  assign hit  = tok & valid & (id == ctl.key);

  always_comb begin
    case (ctl.op)
      CELL_PUSH:   slot_next = prev_slot;
      CELL_POP:    slot_next = next_slot;
      CELL_SEARCH: slot_next = (tok && (ctl.compact || hit)) ? next_slot : slot;
      default:     slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
    end else begin
      valid <= slot_next.valid;
      tok   <= (ctl.op == CELL_SEARCH) ? (prev_tok & prev_slot.valid) : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    id <= slot_next.id;
  end

endmodule

/* src/ewait_chain.sv */
// Row of waiter cells, newest waiter in cell 0
module ewait_chain import ewait_pkg::*; #(
  parameter int MAX_WAITERS = DEF_MAX_WAITERS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  chain_ctl_t              ctl,
  input  logic [TASK_ID_BITS-1:0] new_id,
  input  logic                    inject,
  output chain_stat_t             stat,
  output logic [MAX_WAITERS-1:0]  tok_vec,
  output logic [MAX_WAITERS-1:0]  valid_vec
);

  slot_t                  cur [MAX_WAITERS+1];
  logic [MAX_WAITERS-1:0] hit_vec;

  assign cur[MAX_WAITERS] = '0;

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    slot_t prev_slot;
    logic  prev_tok;

    if (i == 0) begin : g_head
      assign prev_slot = '{valid: 1'b1, id: new_id};
      assign prev_tok  = inject;
    end else begin : g_body
      assign prev_slot = cur[i-1];
      assign prev_tok  = tok_vec[i-1];
    end

    ewait_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_slot (prev_slot),
      .next_slot (cur[i+1]),
      .prev_tok  (prev_tok),
      .slot      (cur[i]),
      .tok       (tok_vec[i]),
      .hit       (hit_vec[i])
    );

    assign valid_vec[i] = cur[i].valid;
  end

  assign stat.top          = cur[0];
  assign stat.second_valid = cur[1].valid;
  assign stat.full         = cur[MAX_WAITERS-1].valid;
  assign stat.hit          = |hit_vec;
  assign stat.stop         = (|(tok_vec & ~valid_vec)) | tok_vec[MAX_WAITERS-1];

endmodule

/* src/event_waiter_wakeup.sv */
// Event with a LIFO stack of waiting tasks, auto or manual reset wakeup
//
//  channel   handshake            payload
//  request   start / busy         req    (req_type, task_id)
//  result    done, one cycle      result (woken_task .. last_result)
//  config    APB, pready high     event_mode at byte address 0
//
// Reset, wait and a set waking at most one waiter end on accept; the result
// is registered and shows on the next cycle. A manual set wakes one waiter per
// cycle, newest first. A cancel walks a token down the cell row, one cell a
// cycle, busy up to an empty or the last cell; result in the cycle after.
// rst clears the flag, the stack occupancy, the mode and the sequencer.
// Results cannot be stalled; done marks each beat for one cycle.
`include "assert_macros.svh"

module event_waiter_wakeup import ewait_pkg::*; #(
  parameter int MAX_WAITERS = DEF_MAX_WAITERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ewait_req_t  req,
  output logic        done,
  output ewait_res_t  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ewait_state_t            state, state_next;
  logic                    set_flag, set_flag_next;
  logic                    event_mode;
  logic                    compact, compact_next;
  logic [TASK_ID_BITS-1:0] key, key_next;
  logic                    done_next;
  ewait_res_t              result_next;
  chain_ctl_t              ctl;
  logic                    inject;
  chain_stat_t             stat;
  logic [MAX_WAITERS-1:0]  tok_vec;
  logic [MAX_WAITERS-1:0]  valid_vec;
  logic                    accept;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_EVENT_MODE) ? {31'b0, event_mode} : 32'b0;

  ewait_chain #(.MAX_WAITERS(MAX_WAITERS)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .new_id    (req.task_id),
    .inject    (inject),
    .stat      (stat),
    .tok_vec   (tok_vec),
    .valid_vec (valid_vec)
  );

  always_comb begin
    state_next    = state;
    set_flag_next = set_flag;
    compact_next  = compact;
    key_next      = key;
    done_next     = 1'b0;
    result_next   = '0;
    result_next.last_result = 1'b1;
    ctl           = '{op: CELL_HOLD, compact: compact, key: key};
    inject        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_SET: begin
              done_next = 1'b1;
              if (set_flag) begin
                result_next.flag_now = 1'b1;
              end else if (!stat.top.valid) begin
                set_flag_next        = 1'b1;
                result_next.flag_now = 1'b1;
              end else begin
                ctl.op                 = CELL_POP;
                result_next.woken_task = stat.top.id;
                result_next.wake_valid = 1'b1;
                if (event_mode != MODE_AUTO) begin
                  result_next.flag_now    = ~stat.second_valid;
                  result_next.last_result = ~stat.second_valid;
                  if (stat.second_valid) begin
                    state_next = ST_MSET;
                  end else begin
                    set_flag_next = 1'b1;
                  end
                end
              end
            end
            REQ_RESET: begin
              done_next     = 1'b1;
              set_flag_next = 1'b0;
            end
            REQ_WAIT: begin
              done_next = 1'b1;
              if (set_flag) begin
                result_next.flag_now = 1'b1;
              end else if (stat.full) begin
                result_next.stack_overflow = 1'b1;
              end else begin
                ctl.op                 = CELL_PUSH;
                result_next.must_block = 1'b1;
              end
            end
            REQ_CANCEL: begin
              ctl.op       = CELL_SEARCH;
              inject       = 1'b1;
              compact_next = 1'b0;
              key_next     = req.task_id;
              state_next   = ST_CANCEL;
            end
            default: ;
          endcase
        end
      end
      ST_MSET: begin
        ctl.op                  = CELL_POP;
        done_next               = 1'b1;
        result_next.woken_task  = stat.top.id;
        result_next.wake_valid  = 1'b1;
        result_next.flag_now    = ~stat.second_valid;
        result_next.last_result = ~stat.second_valid;
        if (!stat.second_valid) begin
          set_flag_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        ctl.op = CELL_SEARCH;
        if (stat.hit) begin
          compact_next = 1'b1;
        end
        if (stat.stop) begin
          done_next              = 1'b1;
          result_next.wake_valid = compact | stat.hit;
          result_next.woken_task = (compact | stat.hit) ? key : '0;
          result_next.flag_now   = set_flag;
          state_next             = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      set_flag   <= 1'b0;
      compact    <= 1'b0;
      done       <= 1'b0;
      event_mode <= 1'b0;
    end else begin
      state    <= state_next;
      set_flag <= set_flag_next;
      compact  <= compact_next;
      done     <= done_next;
      if (cfg_write && paddr[2] == REG_EVENT_MODE) begin
        event_mode <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    result <= result_next;
  end

  `EWW_ASSERT(a_tok_onehot, clk, rst, $onehot0(tok_vec), "more than one search token")
  `EWW_ASSERT(a_stack_packed, clk, rst, ((valid_vec >> 1) & ~valid_vec) == '0, "stack gap")
  `EWW_ASSERT(a_accept_moves, clk, rst, accept |=> (done || busy), "accepted request stalled")
  `EWW_ASSERT(a_wake_excl, clk, rst, done && result.wake_valid |-> !result.must_block && !result.stack_overflow, "wake with block")
  `EWW_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !done && !busy, "beat or busy after reset")

endmodule

/* dv/event_waiter_wakeup_tb.sv */
// Self-checking testbench for event_waiter_wakeup: random and directed requests vs. a predictor
`timescale 1ns / 1ps

module event_waiter_wakeup_tb import ewait_pkg::*;;

  localparam logic [2:0] ADDR_EVENT_MODE = {REG_EVENT_MODE, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;
  localparam int         PHASE_ITEMS     = 70;
  localparam int         NUM_PHASES      = 6;
  localparam int         REPORT_LIMIT    = 10;

  class wake_scoreboard;
    logic                    flag;
    logic                    mode;
    logic [TASK_ID_BITS-1:0] waiters [DEF_MAX_WAITERS];
    int                      depth;
    ewait_res_t              pending_results [$];
    int requests, results, wakes, queued, overflows, cancel_hits, cancel_misses;
    int failures, mismatches;

    function new();
      flag = 1'b0;
      mode = 1'b0;
      depth = 0;
    endfunction

    function void expect_beat(logic [TASK_ID_BITS-1:0] task_id, logic wake, logic block,
                              logic flag_now, logic ovf, logic last);
      ewait_res_t r;
      r.woken_task     = task_id;
      r.wake_valid     = wake;
      r.must_block     = block;
      r.flag_now       = flag_now;
      r.stack_overflow = ovf;
      r.last_result    = last;
      pending_results.push_back(r);
    endfunction

    function void note_request(ewait_req_t r);
      int i;
      int hit;
      requests++;
      case (r.req_type)
        REQ_SET: begin
          if (flag) begin
            expect_beat('0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
          end else if (depth == 0) begin
            flag = 1'b1;
            expect_beat('0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
          end else if (mode == MODE_AUTO) begin
            depth--;
            wakes++;
            expect_beat(waiters[depth], 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
          end else begin
            while (depth > 0) begin
              depth--;
              wakes++;
              if (depth == 0) flag = 1'b1;
              expect_beat(waiters[depth], 1'b1, 1'b0, depth == 0, 1'b0, depth == 0);
            end
          end
        end
        REQ_RESET: begin
          flag = 1'b0;
          expect_beat('0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
        REQ_WAIT: begin
          if (flag) begin
            expect_beat('0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
          end else if (depth >= DEF_MAX_WAITERS) begin
            overflows++;
            expect_beat('0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
          end else begin
            waiters[depth] = r.task_id;
            depth++;
            queued++;
            expect_beat('0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
          end
        end
        default: begin
          hit = -1;
          for (i = depth - 1; i >= 0 && hit < 0; i--) begin
            if (waiters[i] == r.task_id) hit = i;
          end
          if (hit >= 0) begin
            for (i = hit; i + 1 < depth; i++) waiters[i] = waiters[i + 1];
            depth--;
            cancel_hits++;
            wakes++;
            expect_beat(r.task_id, 1'b1, 1'b0, flag, 1'b0, 1'b1);
          end else begin
            cancel_misses++;
            expect_beat('0, 1'b0, 1'b0, flag, 1'b0, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_result(ewait_res_t got);
      ewait_res_t exp;
      results++;
      if (pending_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected beat task=%0h wake=%0b block=%0b flag=%0b ovf=%0b last=%0b",
                   $time, got.woken_task, got.wake_valid, got.must_block, got.flag_now,
                   got.stack_overflow, got.last_result);
        return;
      end
      exp = pending_results.pop_front();
      if (got.woken_task !== exp.woken_task || got.wake_valid !== exp.wake_valid ||
          got.must_block !== exp.must_block || got.flag_now !== exp.flag_now ||
          got.stack_overflow !== exp.stack_overflow || got.last_result !== exp.last_result)
      begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch expected task=%0h wake=%0b block=%0b flag=%0b ovf=%0b last=%0b",
                   $time, exp.woken_task, exp.wake_valid, exp.must_block, exp.flag_now,
                   exp.stack_overflow, exp.last_result);
          $display("%0t:          actual   task=%0h wake=%0b block=%0b flag=%0b ovf=%0b last=%0b",
                   $time, got.woken_task, got.wake_valid, got.must_block, got.flag_now,
                   got.stack_overflow, got.last_result);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  ewait_req_t  req = '0;
  logic        done;
  ewait_res_t  result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wake_scoreboard sb = new();
  bit             no_gaps;
  int             mode_writes;

  event_waiter_wakeup u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [TASK_ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return TASK_ID_BITS'($urandom_range(0, 3));
    if (r == 2) return $urandom_range(0, 1) ? '1 : '0;
    return TASK_ID_BITS'($urandom());
  endfunction

  function automatic logic [TASK_ID_BITS-1:0] live_id();
    if (sb.depth == 0) return pick_id();
    return sb.waiters[$urandom_range(0, sb.depth - 1)];
  endfunction

  task automatic send(logic [1:0] kind, logic [TASK_ID_BITS-1:0] id);
    ewait_req_t r;
    int gap;
    r.req_type = kind;
    r.task_id  = id;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() > 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_mode(logic m);
    logic [31:0] v;
    wait_idle();
    v = $urandom();
    v[0] = m;
    write_reg(ADDR_EVENT_MODE, v);
    sb.mode = m;
    v = $urandom();
    v[0] = ~m;
    write_reg(ADDR_UNUSED, v);
    mode_writes++;
  endtask

  task automatic fill_stack();
    send(REQ_RESET, pick_id());
    while (sb.depth < DEF_MAX_WAITERS) send(REQ_WAIT, pick_id());
    repeat ($urandom_range(1, 2)) send(REQ_WAIT, pick_id());
    repeat ($urandom_range(0, 3)) send(REQ_CANCEL, live_id());
    repeat ($urandom_range(1, 2)) send(REQ_SET, pick_id());
  endtask

  initial begin
    int phase_end;
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(~MODE_AUTO);
    send(REQ_SET, 8'h00);
    send(REQ_SET, 8'hFF);
    send(REQ_WAIT, 8'hFF);
    send(REQ_CANCEL, 8'h00);
    send(REQ_RESET, 8'h00);
    send(REQ_RESET, 8'hFF);
    send(REQ_WAIT, 8'h00);
    send(REQ_WAIT, 8'h55);
    send(REQ_WAIT, 8'hFF);
    send(REQ_WAIT, 8'h55);
    send(REQ_WAIT, 8'hAA);
    send(REQ_CANCEL, 8'h55);
    send(REQ_CANCEL, 8'h12);
    send(REQ_SET, 8'h00);
    send(REQ_WAIT, 8'h01);
    send(REQ_RESET, 8'h00);
    write_mode(MODE_AUTO);
    send(REQ_WAIT, 8'h10);
    send(REQ_WAIT, 8'h20);
    send(REQ_SET, 8'h00);
    send(REQ_SET, 8'h00);
    send(REQ_SET, 8'h00);
    send(REQ_RESET, 8'h00);
    send(REQ_WAIT, 8'h7F);
    send(REQ_CANCEL, 8'h7F);
    send(REQ_CANCEL, 8'h7F);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_mode(phase < 2 ? logic'(phase[0]) : logic'($urandom_range(0, 1)));
      phase_end = sb.requests + PHASE_ITEMS;
      no_gaps = 1'b0;
      fill_stack();
      while (sb.requests < phase_end) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if ($urandom_range(0, 1)) send(REQ_RESET, pick_id());
            repeat ($urandom_range(1, 6)) send(REQ_WAIT, pick_id());
            if ($urandom_range(0, 2) == 0) send(REQ_CANCEL, live_id());
            repeat ($urandom_range(1, 3)) send(REQ_SET, pick_id());
          end
          4: fill_stack();
          5, 6: repeat ($urandom_range(1, 3)) begin
            send(REQ_CANCEL, $urandom_range(0, 3) == 0 ? pick_id() : live_id());
          end
          default: repeat ($urandom_range(1, 4)) send(2'($urandom_range(0, 3)), pick_id());
        endcase
      end
    end

    start <= 1'b0;
    waited = 0;
    while (sb.pending_results.size() > 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending_results.size() > 0) begin
      $display("%0d expected beats never arrived", sb.pending_results.size());
      sb.failures += sb.pending_results.size();
    end

    $display("Ran %0d requests in %0d mode settings; %0d result beats, %0d wakes",
             sb.requests, mode_writes, sb.results, sb.wakes);
    $display("Queued waits %0d, stack overflows %0d, cancel hits %0d, misses %0d, mismatches %0d",
             sb.queued, sb.overflows, sb.cancel_hits, sb.cancel_misses, sb.mismatches);
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ewait_pkg.sv
src/ewait_cell.sv
src/ewait_chain.sv
src/event_waiter_wakeup.sv
dv/event_waiter_wakeup_tb.sv
